FILE: hdl/pmp_pkg.sv
package pmp_pkg;

    localparam int ANG_W = 40;
    localparam int CW = 34;
    localparam int ATAN_ENTRIES = 24;
    localparam int REDUCE_STEPS = 6;

    localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 40'sd6746518852;
    localparam logic signed [ANG_W-1:0] ANG_PI = 40'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 40'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_BIAS = 40'sd215888603264;
    localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;

    localparam logic [12:0] BLEND_ONE = 13'd4096;
    localparam logic signed [12:0] PIX_MIN = -13'sd4096;
    localparam logic signed [12:0] PIX_MAX = 13'sd4095;

    localparam logic [1:0] REG_BLEND = 2'd0;
    localparam logic [1:0] REG_SCALE = 2'd1;
    localparam logic [1:0] REG_OFFSET_X = 2'd2;
    localparam logic [1:0] REG_OFFSET_Y = 2'd3;

    localparam logic [29:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686, 30'd33543515, 30'd16775850, 30'd8388437,
        30'd4194282, 30'd2097149, 30'd1048575, 30'd524287,
        30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047,
        30'd1023, 30'd511, 30'd255, 30'd127
    };

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic neg;
    } side_t;

endpackage

FILE: hdl/pmp_angle_reduce.sv
module pmp_angle_reduce #(
    parameter int FRAC_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic signed [15:0] in_px,
    input  logic signed [15:0] in_py,
    output logic out_valid,
    output logic signed [pmp_pkg::CW-1:0] out_z,
    output pmp_pkg::side_t out_side
);
    import pmp_pkg::*;

    localparam int SH = 30 - FRAC_BITS;

    logic v_reg [0:REDUCE_STEPS];
    logic signed [ANG_W-1:0] a_reg [0:REDUCE_STEPS];
    side_t s_reg [0:REDUCE_STEPS];
    logic signed [ANG_W-1:0] wrap;
    logic signed [ANG_W-1:0] fold;
    logic neg;
    logic fv_reg;
    logic signed [CW-1:0] z_reg;
    side_t fs_reg;

    // biased so the angle is never negative before the subtract steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            a_reg[0] <= (ANG_W'(in_py) <<< SH) + ANG_BIAS;
            s_reg[0] <= '{px: in_px, py: in_py, neg: 1'b0};
        end
    end

    for (genvar k = 0; k < REDUCE_STEPS; k++)
    begin : g_step
        localparam logic signed [ANG_W-1:0] SUB = ANG_TWO_PI <<< (REDUCE_STEPS - 1 - k);
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
                a_reg[k+1] <= (a_reg[k] >= SUB) ? a_reg[k] - SUB : a_reg[k];
                s_reg[k+1] <= s_reg[k];
            end
        end
    end

    always_comb
    begin
        wrap = (a_reg[REDUCE_STEPS] >= ANG_PI) ? a_reg[REDUCE_STEPS] - ANG_TWO_PI
                                               : a_reg[REDUCE_STEPS];
        neg = 1'b0;
        fold = wrap;
        if (wrap > ANG_HALF_PI)
        begin
            fold = wrap - ANG_PI;
            neg = 1'b1;
        end
        else if (wrap < -ANG_HALF_PI)
        begin
            fold = wrap + ANG_PI;
            neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= v_reg[REDUCE_STEPS];
            z_reg <= CW'(fold);
            fs_reg <= '{px: s_reg[REDUCE_STEPS].px, py: s_reg[REDUCE_STEPS].py, neg: neg};
        end
    end

    assign out_valid = fv_reg;
    assign out_z = z_reg;
    assign out_side = fs_reg;

endmodule

FILE: hdl/pmp_cordic.sv
module pmp_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic signed [pmp_pkg::CW-1:0] in_z,
    input  pmp_pkg::side_t in_side,
    output logic out_valid,
    output logic signed [pmp_pkg::CW-1:0] out_x,
    output logic signed [pmp_pkg::CW-1:0] out_y,
    output pmp_pkg::side_t out_side
);
    import pmp_pkg::*;

    logic v_reg [1:CORDIC_STAGES];
    logic signed [CW-1:0] x_reg [1:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [1:CORDIC_STAGES];
    logic signed [CW-1:0] z_reg [1:CORDIC_STAGES];
    side_t s_reg [1:CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam logic signed [CW-1:0] ATAN = CW'(ATAN_TAB[i]);
        logic v_cur;
        logic signed [CW-1:0] x_cur;
        logic signed [CW-1:0] y_cur;
        logic signed [CW-1:0] z_cur;
        side_t s_cur;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        // first stage starts from the gain-corrected unit vector
        if (i == 0)
        begin : g_first
            assign v_cur = in_valid;
            assign x_cur = GAIN_INV;
            assign y_cur = '0;
            assign z_cur = in_z;
            assign s_cur = in_side;
        end
        else
        begin : g_next
            assign v_cur = v_reg[i];
            assign x_cur = x_reg[i];
            assign y_cur = y_reg[i];
            assign z_cur = z_reg[i];
            assign s_cur = s_reg[i];
        end

        assign dx = y_cur >>> i;
        assign dy = x_cur >>> i;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_cur;
                s_reg[i+1] <= s_cur;
                if (!z_cur[CW-1])
                begin
                    x_reg[i+1] <= x_cur - dx;
                    y_reg[i+1] <= y_cur + dy;
                    z_reg[i+1] <= z_cur - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_cur + dx;
                    y_reg[i+1] <= y_cur - dy;
                    z_reg[i+1] <= z_cur + ATAN;
                end
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STAGES];
    assign out_x = x_reg[CORDIC_STAGES];
    assign out_y = y_reg[CORDIC_STAGES];
    assign out_side = s_reg[CORDIC_STAGES];

endmodule

FILE: hdl/pmp_blend.sv
module pmp_blend #(
    parameter int FRAC_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic signed [pmp_pkg::CW-1:0] in_x,
    input  logic signed [pmp_pkg::CW-1:0] in_y,
    input  pmp_pkg::side_t in_side,
    input  logic [12:0] blend,
    input  logic [7:0] scale,
    input  logic [9:0] offset_x,
    input  logic [9:0] offset_y,
    output logic out_valid,
    output logic signed [12:0] out_px,
    output logic signed [12:0] out_py
);
    import pmp_pkg::*;

    localparam int SHIFT = FRAC_BITS + 28;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [CW-1:0] c1_reg, s1_reg;
    logic signed [15:0] px1_reg, py1_reg, px2_reg, py2_reg;
    logic signed [49:0] mx2_reg, my2_reg;
    logic signed [49:0] tmx3_reg, tmy3_reg, omx3_reg, omy3_reg;
    logic signed [50:0] sx4_reg, sy4_reg;
    logic signed [60:0] qx5_reg, qy5_reg;
    logic signed [12:0] px6_reg, py6_reg;

    logic [12:0] b;
    logic signed [13:0] bs, nbs;
    logic signed [35:0] tx, ty;
    logic signed [31:0] ox, oy;
    logic signed [8:0] sc;

    function automatic logic signed [12:0] to_pixel(
        input logic signed [60:0] q,
        input logic [9:0] off
    );
        logic signed [61:0] p;
        p = 62'(q >>> SHIFT) + 62'(signed'({1'b0, off}));
        if (p < 62'(PIX_MIN))
            return PIX_MIN;
        else if (p > 62'(PIX_MAX))
            return PIX_MAX;
        else
            return p[12:0];
    endfunction

    always_comb
    begin
        b = (blend > BLEND_ONE) ? BLEND_ONE : blend;
        bs = signed'({1'b0, b});
        nbs = signed'({1'b0, BLEND_ONE - b});
        tx = 36'(mx2_reg >>> 14);
        ty = 36'(my2_reg >>> 14);
        ox = {px2_reg, 16'd0};
        oy = {py2_reg, 16'd0};
        sc = signed'({1'b0, scale});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            // undo the half-turn fold
            c1_reg <= in_side.neg ? -in_x : in_x;
            s1_reg <= in_side.neg ? -in_y : in_y;
            px1_reg <= in_side.px;
            py1_reg <= in_side.py;
            mx2_reg <= 50'(px1_reg) * 50'(c1_reg);
            my2_reg <= 50'(px1_reg) * 50'(s1_reg);
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            tmx3_reg <= 50'(bs) * 50'(tx);
            tmy3_reg <= 50'(bs) * 50'(ty);
            omx3_reg <= 50'(nbs) * 50'(ox);
            omy3_reg <= 50'(nbs) * 50'(oy);
            sx4_reg <= 51'(tmx3_reg) + 51'(omx3_reg);
            sy4_reg <= 51'(tmy3_reg) + 51'(omy3_reg);
            qx5_reg <= 61'(sx4_reg) * 61'(sc);
            qy5_reg <= 61'(sy4_reg) * 61'(sc);
            px6_reg <= to_pixel(qx5_reg, offset_x);
            py6_reg <= to_pixel(qy5_reg, offset_y);
        end
    end

    assign out_valid = v6_reg;
    assign out_px = px6_reg;
    assign out_py = py6_reg;

endmodule

FILE: hdl/polar_morph_point_plotter_top.sv
// Point transform pipeline: each point is read both as (x, y) and as (radius,
// angle), the polar form is rotated by a CORDIC chain and blended with the
// original, then scaled, offset and saturated to pixel coordinates. One point
// is taken every clock (busy stays low) and its pixel appears with done after
// passing the angle reduction registers, the registered CORDIC stages and the
// multiply, blend and scaling registers. The receiver cannot stall, so done
// marks a one-cycle result that must be taken.
// Configuration is written through cfg_valid/cfg_ready and must only change
// while no point is in flight.
module polar_morph_point_plotter_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    output logic done,
    output logic signed [12:0] pixel_x,
    output logic signed [12:0] pixel_y,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [12:0] cfg_data
);
    import pmp_pkg::*;

    logic [12:0] blend_reg;
    logic [7:0] scale_reg;
    logic [9:0] offset_x_reg;
    logic [9:0] offset_y_reg;

    logic red_valid;
    logic signed [CW-1:0] red_z;
    side_t red_side;
    logic cor_valid;
    logic signed [CW-1:0] cor_x, cor_y;
    side_t cor_side;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg <= 13'd0;
            scale_reg <= 8'd50;
            offset_x_reg <= 10'd500;
            offset_y_reg <= 10'd500;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BLEND:    blend_reg <= cfg_data;
                REG_SCALE:    scale_reg <= cfg_data[7:0];
                REG_OFFSET_X: offset_x_reg <= cfg_data[9:0];
                REG_OFFSET_Y: offset_y_reg <= cfg_data[9:0];
                default:      ;
            endcase
        end
    end

    pmp_angle_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(start && !busy),
        .in_px(point_x),
        .in_py(point_y),
        .out_valid(red_valid),
        .out_z(red_z),
        .out_side(red_side)
    );

    pmp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(red_valid),
        .in_z(red_z),
        .in_side(red_side),
        .out_valid(cor_valid),
        .out_x(cor_x),
        .out_y(cor_y),
        .out_side(cor_side)
    );

    pmp_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(cor_valid),
        .in_x(cor_x),
        .in_y(cor_y),
        .in_side(cor_side),
        .blend(blend_reg),
        .scale(scale_reg),
        .offset_x(offset_x_reg),
        .offset_y(offset_y_reg),
        .out_valid(done),
        .out_px(pixel_x),
        .out_py(pixel_y)
    );

endmodule

FILE: tb/sv/polar_morph_point_plotter_top_tb.sv
`timescale 1ns / 100ps

module polar_morph_point_plotter_top_tb;
    import pmp_pkg::*;

    localparam int STAGES = 16;
    localparam int FRAC = 12;
    localparam int LATENCY = STAGES + 14;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
    } point_t;

    typedef struct {
        logic signed [12:0] x;
        logic signed [12:0] y;
    } pixel_t;

    typedef struct {
        logic [1:0] idx;
        logic [12:0] data;
    } cfg_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic done;
    logic signed [12:0] pixel_x;
    logic signed [12:0] pixel_y;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [12:0] cfg_data;

    point_t point_q[$];
    pixel_t pixel_q[$];
    cfg_t cfg_q[$];

    logic [12:0] m_blend;
    logic [7:0] m_scale;
    logic [9:0] m_off_x;
    logic [9:0] m_off_y;

    bit no_idle;
    int mismatches;

    polar_morph_point_plotter_top #(
        .CORDIC_STAGES(STAGES),
        .FRAC_BITS(FRAC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .point_x(point_x),
        .point_y(point_y),
        .done(done),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic logic signed [12:0] to_screen(longint sum, longint scale, longint offset);
        longint p;
        p = ((sum * scale) >>> (FRAC + 28)) + offset;
        if (p < -4096)
            p = -4096;
        if (p > 4095)
            p = 4095;
        return p[12:0];
    endfunction

    function automatic pixel_t plot_point(logic signed [15:0] px_in, logic signed [15:0] py_in);
        longint px, py, r, x, y, z, dx, dy, tx, ty, b, sx, sy;
        bit flip;
        pixel_t res;
        px = px_in;
        py = py_in;
        r = (py <<< (30 - FRAC)) % longint'(ANG_TWO_PI);
        flip = 0;
        if (r < 0)
            r += ANG_TWO_PI;
        if (r >= ANG_PI)
            r -= ANG_TWO_PI;
        // fold into the right half plane, negating the result
        if (r > ANG_HALF_PI)
        begin
            r -= ANG_PI;
            flip = 1;
        end
        else if (r < -longint'(ANG_HALF_PI))
        begin
            r += ANG_PI;
            flip = 1;
        end
        x = GAIN_INV;
        y = 0;
        z = r;
        for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_TAB[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_TAB[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        tx = (px * x) >>> 14;
        ty = (px * y) >>> 14;
        b = (m_blend > BLEND_ONE) ? 4096 : longint'(m_blend);
        sx = (4096 - b) * (px <<< 16) + b * tx;
        sy = (4096 - b) * (py <<< 16) + b * ty;
        res.x = to_screen(sx, m_scale, m_off_x);
        res.y = to_screen(sy, m_scale, m_off_y);
        return res;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // point driver; the expected pixel is computed at the accepting edge
    always @(posedge clk or negedge rst_n)
    begin
        point_t p;
        if (!rst_n)
        begin
            start <= 0;
            point_x <= 0;
            point_y <= 0;
        end
        else
        begin
            if (start && !busy)
                pixel_q = {pixel_q, plot_point(point_x, point_y)};
            if (!start || !busy)
            begin
                if (point_q.size() > 0 && (no_idle || $urandom_range(99) >= 17))
                begin
                    p = point_q.pop_front();
                    start <= 1;
                    point_x <= p.px;
                    point_y <= p.py;
                end
                else
                begin
                    start <= 0;
                    point_x <= $urandom;
                    point_y <= $urandom;
                end
            end
        end
    end

    // register write channel
    always @(posedge clk or negedge rst_n)
    begin
        cfg_t c;
        if (!rst_n)
        begin
            cfg_valid <= 0;
            cfg_index <= REG_BLEND;
            cfg_data <= 0;
            m_blend <= 0;
            m_scale <= 50;
            m_off_x <= 500;
            m_off_y <= 500;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BLEND: m_blend <= cfg_data;
                    REG_SCALE: m_scale <= cfg_data[7:0];
                    REG_OFFSET_X: m_off_x <= cfg_data[9:0];
                    REG_OFFSET_Y: m_off_y <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (cfg_q.size() > 0 && (no_idle || $urandom_range(99) >= 17))
                begin
                    c = cfg_q.pop_front();
                    cfg_valid <= 1;
                    cfg_index <= c.idx;
                    cfg_data <= c.data;
                end
                else
                    cfg_valid <= 0;
            end
        end
    end

    // pixel monitor
    always @(posedge clk)
    begin
        pixel_t e;
        if (rst_n && done)
        begin
            if (pixel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel transfer: x=%0d y=%0d", pixel_x, pixel_y);
            end
            else
            begin
                e = pixel_q.pop_front();
                if (pixel_x !== e.x || pixel_y !== e.y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected (%0d,%0d) got (%0d,%0d)",
                                 e.x, e.y, pixel_x, pixel_y);
                end
            end
        end
    end

    task automatic add_point(int px, int py);
        point_t p;
        p.px = 16'(px);
        p.py = 16'(py);
        point_q = {point_q, p};
    endtask

    task automatic add_cfg(logic [1:0] idx, int data);
        cfg_t c;
        c.idx = idx;
        c.data = 13'(data);
        cfg_q = {cfg_q, c};
    endtask

    // register writes land before any point of the next batch is sent
    task automatic wait_cfg();
        while (cfg_q.size() > 0 || cfg_valid)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic directed_points();
        add_point(0, 0);
        add_point(32767, 32767);
        add_point(-32768, -32768);
        add_point(32767, -32768);
        add_point(-32768, 32767);
        add_point(4096, 12868);     // just past pi
        add_point(4096, 12867);
        add_point(4096, 6434);      // around half pi
        add_point(4096, -6434);
        add_point(4096, 6433);
        add_point(-4096, 4096);     // negative radius
        add_point(8192, 25736);     // large angle
        add_point(-1, -1);
        add_point(16'h5555, 16'haaaa);
    endtask

    task automatic random_points(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                add_point($urandom, $urandom);
            else
                add_point($urandom_range(16383) - 8192, $urandom_range(16383) - 8192);
        end
    endtask

    task automatic drain();
        while (point_q.size() > 0 || cfg_q.size() > 0 || start || cfg_valid
               || pixel_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        no_idle = 0;
        mismatches = 0;
        repeat (6) @(posedge clk);
        rst_n = 1;

        directed_points();
        random_points(150);
        drain();

        add_cfg(REG_BLEND, 4096);
        wait_cfg();
        directed_points();
        random_points(200);
        drain();

        // blend above one, scale zero, offsets at both ends
        add_cfg(REG_BLEND, 8191);
        add_cfg(REG_SCALE, 13'h1f00);
        add_cfg(REG_OFFSET_X, 0);
        add_cfg(REG_OFFSET_Y, 13'h1fff);
        wait_cfg();
        directed_points();
        random_points(50);
        drain();

        add_cfg(REG_BLEND, 2048);
        add_cfg(REG_SCALE, 255);
        add_cfg(REG_OFFSET_X, 1023);
        add_cfg(REG_OFFSET_Y, 0);
        wait_cfg();
        directed_points();
        random_points(200);
        drain();

        add_cfg(REG_SCALE, 1);
        add_cfg(REG_BLEND, 4097);
        wait_cfg();
        no_idle = 1;
        random_points(250);
        drain();
        no_idle = 0;

        for (int k = 0; k < 4; k++)
        begin
            add_cfg(REG_BLEND, $urandom_range(8191));
            add_cfg(REG_SCALE, $urandom);
            add_cfg(REG_OFFSET_X, $urandom);
            add_cfg(REG_OFFSET_Y, $urandom);
            wait_cfg();
            random_points(125);
            drain();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
